// ----- rtl/msl_pkg.sv -----
// shared types and constants for the masked sum log loss block
// used by msl_div and masked_sum_log_loss_with_gradient; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package msl_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int VAL_W       = 16;
  localparam int SUM_W       = 24;
  localparam int LOSS_W      = 32;
  localparam int CL_W        = 22;
  localparam int MEAN_W      = 22;
  localparam int GRAD_W      = 31;
  localparam int CNT_W       = 9;
  localparam int DVD_W       = 32;

  localparam logic [SUM_W-1:0]  SUM_MAX      = 24'hFF_FFFF;
  localparam logic [31:0]       LN2_Q32      = 32'hB172_17F8;
  localparam logic [CL_W-1:0]   COL_LOSS_MAX = 22'd2097151;
  localparam logic [CNT_W-1:0]  COUNT_MAX    = 9'd511;
  localparam logic [DVD_W-1:0]  GRAD_MAG_MAX = 32'd1073741824;
  localparam logic [DVD_W-1:0]  MEAN_POS_LIM = 32'd2097151;
  localparam logic [DVD_W-1:0]  MEAN_NEG_LIM = 32'd2097152;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_GRAD = 1'b1;
  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/msl_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on msl_pkg
`timescale 1ns / 1ps
`default_nettype none
module msl_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire msl_pkg::div_req_t req,
  output msl_pkg::div_rsp_t      rsp
);

  logic [msl_pkg::SUM_W-1:0] rem_r, rem_nxt;
  logic [msl_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [msl_pkg::SUM_W-1:0] dsr_r;
  logic [5:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [msl_pkg::SUM_W:0]   trial;
  logic                      qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[msl_pkg::DVD_W-1]};
    qbit    = (trial >= {1'b0, dsr_r});
    rem_nxt = qbit ? msl_pkg::SUM_W'(trial - {1'b0, dsr_r}) : trial[msl_pkg::SUM_W-1:0];
    dvd_nxt = {dvd_r[msl_pkg::DVD_W-2:0], qbit};
    cnt_nxt = cnt_r - 6'd1;
    busy_nxt = busy_r && (cnt_r != 6'd1);
    done_nxt = busy_r && (cnt_r == 6'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'(msl_pkg::DVD_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
`default_nettype wire

// ----- rtl/masked_sum_log_loss_with_gradient.sv -----
// masked sum log loss with gradient: sequencer, column sum store, shared multiplier
// depends on msl_pkg and msl_div
//
// channel | dir | tdata (low bit up)                  | tuser (low bit up)       | tlast
// in_     | in  | column 8, prediction 16, truth 16   | operation, last_of_column | last_of_batch
// out_    | out | mean_loss 22, gradient_value 31, 0  | result_kind, saturated    | -
//
// evaluate request without column end: updates the running sum and stays in S_IDLE
// column end: leading one search, then 16 squarings on the shared multiplier, then the ln2
//   product; a zero sum skips these; batch end adds the mean division in the divider, output
// gradient request: straight to output with zero truth or zero sum, else through the divider
// reset clears control state only; column sums are undefined until written
// a waiting result holds the sequencer in its output state until taken
`timescale 1ns / 1ps
`default_nettype none
module masked_sum_log_loss_with_gradient (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // column, prediction, truth
  input  wire logic [1:0]  in_tuser,   // operation, last_of_column
  input  wire logic        in_tlast,   // last_of_batch
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // mean_loss, gradient_value, zero fill
  output logic [1:0]       out_tuser   // result_kind, saturated
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_NORM   = 4'd2;
  localparam logic [3:0] S_SQM    = 4'd3;
  localparam logic [3:0] S_SQU    = 4'd4;
  localparam logic [3:0] S_LNM    = 4'd5;
  localparam logic [3:0] S_LNU    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_MEAN   = 4'd8;
  localparam logic [3:0] S_MDIV   = 4'd9;
  localparam logic [3:0] S_GRD_RD = 4'd10;
  localparam logic [3:0] S_GRD_DV = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_r;

  logic [msl_pkg::COL_W-1:0] col_r;
  logic [msl_pkg::VAL_W-1:0] truth_r;
  logic                      lb_r;

  logic [msl_pkg::SUM_W-1:0]  run_sum_r;
  logic signed [msl_pkg::LOSS_W-1:0] loss_r;
  logic [msl_pkg::CNT_W-1:0]  cnt_r;
  logic                       sat_seen_r;

  logic [msl_pkg::SUM_W-1:0] mem [msl_pkg::MAX_COLUMNS];
  logic [msl_pkg::SUM_W-1:0] rd_r;

  logic [msl_pkg::SUM_W-1:0] sh_r;
  logic [4:0]                e_r;
  logic [30:0]               x_r;
  logic [15:0]               frac_r;
  logic [3:0]                i_r;
  logic                      neg_r;
  logic signed [msl_pkg::CL_W-1:0] cl_r;

  logic [63:0] prod_r;
  logic [31:0] mul_a, mul_b;

  logic                        res_kind_r, res_sat_r;
  logic [msl_pkg::MEAN_W-1:0]  res_mean_r;
  logic [msl_pkg::GRAD_W-1:0]  res_grad_r;

  logic                        out_valid_r, out_kind_r, out_sat_r;
  logic [msl_pkg::MEAN_W-1:0]  out_mean_r;
  logic [msl_pkg::GRAD_W-1:0]  out_grad_r;

  msl_pkg::div_req_t div_req;
  msl_pkg::div_rsp_t div_rsp;

  logic                      acc;
  logic [msl_pkg::COL_W-1:0] in_col;
  logic [msl_pkg::VAL_W-1:0] in_pred, in_truth;
  logic [msl_pkg::SUM_W:0]   run_add;
  logic [21:0]               t22;
  logic [20:0]               mag21;
  logic [31:0]               sq;
  logic [63:0]               rnd;
  logic [msl_pkg::CL_W-1:0]  pmag;
  logic signed [msl_pkg::LOSS_W:0] s33;
  logic [msl_pkg::DVD_W-1:0] loss_mag;
  logic [msl_pkg::DVD_W-1:0] q;

  assign in_col   = in_tdata[7:0];
  assign in_pred  = in_tdata[23:8];
  assign in_truth = in_tdata[39:24];
  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    run_add  = {1'b0, run_sum_r} + {9'b0, in_pred};
    t22      = 22'd983040 - {1'b0, e_r, frac_r};
    mag21    = t22[21] ? 21'(-t22) : t22[20:0];
    sq       = prod_r[61:30];
    rnd      = prod_r + 64'h0000_0000_8000_0000;
    pmag     = {1'b0, rnd[52:32]};
    s33      = {loss_r[msl_pkg::LOSS_W-1], loss_r}
               + {{(msl_pkg::LOSS_W+1-msl_pkg::CL_W){cl_r[msl_pkg::CL_W-1]}}, cl_r};
    loss_mag = loss_r[msl_pkg::LOSS_W-1] ? 32'(-loss_r) : 32'(loss_r);
    q        = div_rsp.quotient;
    if (state_r == S_LNM) begin
      mul_a = {11'b0, mag21};
      mul_b = msl_pkg::LN2_Q32;
    end else begin
      mul_a = {1'b0, x_r};
      mul_b = {1'b0, x_r};
    end
    div_req.start    = 1'b0;
    div_req.dividend = loss_mag;
    div_req.divisor  = {{(msl_pkg::SUM_W-msl_pkg::CNT_W){1'b0}}, cnt_r};
    if (state_r == S_MEAN) begin
      div_req.start = (cnt_r != '0);
    end else if (state_r == S_GRD_RD) begin
      div_req.start    = (truth_r != '0) && (rd_r != '0);
      div_req.dividend = {1'b0, truth_r, 15'b0} + {9'b0, rd_r[msl_pkg::SUM_W-1:1]};
      div_req.divisor  = rd_r;
    end
  end

  msl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // column sum store
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      mem[col_r] <= run_sum_r;
    end
    if (acc) begin
      rd_r <= mem[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_sum_r   <= '0;
      loss_r      <= '0;
      cnt_r       <= '0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            col_r   <= in_col;
            truth_r <= in_truth;
            lb_r    <= in_tlast;
            if (in_tuser[0] == msl_pkg::OP_GRAD) begin
              state_r <= S_GRD_RD;
            end else begin
              if (in_truth != '0) begin
                if (run_add[msl_pkg::SUM_W]) begin
                  run_sum_r  <= msl_pkg::SUM_MAX;
                  sat_seen_r <= 1'b1;
                end else begin
                  run_sum_r <= run_add[msl_pkg::SUM_W-1:0];
                end
              end
              if (in_tuser[1] || in_tlast) begin
                state_r <= S_EVAL;
              end
            end
          end
        end
        S_EVAL: begin
          sh_r      <= run_sum_r;
          run_sum_r <= '0;
          e_r       <= 5'd23;
          if (run_sum_r == '0) begin
            cl_r       <= msl_pkg::COL_LOSS_MAX;
            sat_seen_r <= 1'b1;
            state_r    <= S_ACC;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (sh_r[msl_pkg::SUM_W-1]) begin
            x_r     <= {sh_r, 7'b0};
            i_r     <= '0;
            frac_r  <= '0;
            state_r <= S_SQM;
          end else begin
            sh_r <= {sh_r[msl_pkg::SUM_W-2:0], 1'b0};
            e_r  <= e_r - 5'd1;
          end
        end
        S_SQM: begin
          state_r <= S_SQU;
        end
        S_SQU: begin
          if (sq[31]) begin
            x_r <= sq[31:1];
            frac_r[4'd15 - i_r] <= 1'b1;
          end else begin
            x_r <= sq[30:0];
          end
          i_r     <= i_r + 4'd1;
          state_r <= (i_r == 4'd15) ? S_LNM : S_SQM;
        end
        S_LNM: begin
          neg_r   <= t22[21];
          state_r <= S_LNU;
        end
        S_LNU: begin
          cl_r    <= neg_r ? -$signed(pmag) : $signed(pmag);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (s33[msl_pkg::LOSS_W] != s33[msl_pkg::LOSS_W-1]) begin
            loss_r     <= s33[msl_pkg::LOSS_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            sat_seen_r <= 1'b1;
          end else begin
            loss_r <= s33[msl_pkg::LOSS_W-1:0];
          end
          if (cnt_r != msl_pkg::COUNT_MAX) begin
            cnt_r <= cnt_r + 9'd1;
          end else begin
            sat_seen_r <= 1'b1;
          end
          state_r <= lb_r ? S_MEAN : S_IDLE;
        end
        S_MEAN: begin
          neg_r      <= loss_r[msl_pkg::LOSS_W-1];
          res_kind_r <= msl_pkg::KIND_MEAN;
          res_grad_r <= '0;
          if (cnt_r == '0) begin
            res_mean_r <= '0;
            res_sat_r  <= 1'b1;
            loss_r     <= '0;
            sat_seen_r <= 1'b0;
            state_r    <= S_OUT;
          end else begin
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            res_sat_r <= sat_seen_r;
            if (neg_r) begin
              if (q > msl_pkg::MEAN_NEG_LIM) begin
                res_mean_r <= 22'h20_0000;
                res_sat_r  <= 1'b1;
              end else begin
                res_mean_r <= 22'(-q);
              end
            end else if (q > msl_pkg::MEAN_POS_LIM) begin
              res_mean_r <= 22'h1F_FFFF;
              res_sat_r  <= 1'b1;
            end else begin
              res_mean_r <= q[msl_pkg::MEAN_W-1:0];
            end
            loss_r     <= '0;
            cnt_r      <= '0;
            sat_seen_r <= 1'b0;
            state_r    <= S_OUT;
          end
        end
        S_GRD_RD: begin
          res_kind_r <= msl_pkg::KIND_GRAD;
          res_mean_r <= '0;
          if (truth_r == '0) begin
            res_grad_r <= '0;
            res_sat_r  <= 1'b0;
            state_r    <= S_OUT;
          end else if (rd_r == '0) begin
            res_grad_r <= 31'h4000_0000;
            res_sat_r  <= 1'b1;
            state_r    <= S_OUT;
          end else begin
            state_r <= S_GRD_DV;
          end
        end
        S_GRD_DV: begin
          if (div_rsp.done) begin
            if (q > msl_pkg::GRAD_MAG_MAX) begin
              res_grad_r <= 31'h4000_0000;
              res_sat_r  <= 1'b1;
            end else begin
              res_grad_r <= 31'(-q);
              res_sat_r  <= 1'b0;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
      out_kind_r <= res_kind_r;
      out_sat_r  <= res_sat_r;
      out_mean_r <= res_mean_r;
      out_grad_r <= res_grad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_grad_r, out_mean_r};
  assign out_tuser  = {out_sat_r, out_kind_r};

  a_grad_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == msl_pkg::KIND_GRAD) |->
      (out_grad_r[msl_pkg::GRAD_W-1] || (out_grad_r == '0)))
    else $error("gradient result is positive");

  a_mean_grad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == msl_pkg::KIND_MEAN) |-> (out_grad_r == '0))
    else $error("mean result carries a gradient");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == S_MDIV) || (state_r == S_GRD_DV)))
    else $error("divider finished outside a wait state");

endmodule
`default_nettype wire
